/* design/tlge_pkg.sv */
// ----------------------------------------------------------------------------
// tlge_pkg: shared types and constants for the toroidal life engine
// Grid size, request/response payloads, opcodes and sequencer states.
// ----------------------------------------------------------------------------
package tlge_pkg;

  localparam int GRID_SIDE = 128;
  localparam int ROW_W     = $clog2(GRID_SIDE);
  localparam int COORD_W   = 7;
  localparam int OP_W      = 2;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_LOW    = 4'd2;
  localparam logic [3:0] KEEP_HIGH   = 4'd3;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               write_value;
  } req_t;

  typedef struct packed {
    logic            read_value;
    logic [OP_W-1:0] finished_op;
  } rsp_t;

  // 3x3 window around one cell, column order {right, center, left}
  typedef struct packed {
    logic [2:0] up;
    logic [2:0] mid;
    logic [2:0] dn;
  } window_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_LOAD_UP,
    ST_LOAD_CUR,
    ST_LOAD_DN,
    ST_SWEEP,
    ST_WRITEBACK,
    ST_DONE
  } state_t;

endpackage

/* design/toroidal_life_generation_engine.sv */
// ----------------------------------------------------------------------------
// toroidal_life_generation_engine: Game of Life (B3/S23) on a wrapped grid
// Row-wide cell store with a one-cell-per-cycle generation sweep.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) carries one opcode per request:
//   write one cell, read one cell, or step one generation. Every request
//   returns exactly one response on rsp (rsp_valid/rsp_stall/rsp) with the
//   opcode echoed and, for a read, the addressed cell.
//   The block takes one request at a time; req_stall stays high until the
//   request has finished its work.
//   A read or write does one row read of the store, then the update or
//   select, before its response; an unused opcode responds directly.
//   A step sweeps the whole grid (GRID_SIDE by GRID_SIDE cells, 128 a side):
//   the sweep evaluates one cell per cycle through a single rule unit, plus
//   a row load and a row write-back per grid row.
//   Reset clears every cell: a clearing pass writes one row per cycle over
//   all GRID_SIDE rows (128), during which req_stall is high.
//   A response held by rsp_stall stays in the output register; the next
//   request may be accepted meanwhile, and its own response waits for the
//   register to free up.
// ----------------------------------------------------------------------------
module toroidal_life_generation_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  tlge_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output tlge_pkg::rsp_t rsp
);
  import tlge_pkg::*;

  state_t state, state_next;

  logic [GRID_SIDE-1:0] cell_grid [GRID_SIDE];
  logic [GRID_SIDE-1:0] rd_data;
  logic [ROW_W-1:0]     rd_addr;
  logic                 mem_we;
  logic [ROW_W-1:0]     mem_waddr;
  logic [GRID_SIDE-1:0] mem_wdata;

  req_t                 cmd;
  logic                 rd_bit;
  logic [ROW_W-1:0]     row;
  logic [ROW_W-1:0]     col;
  logic [GRID_SIDE-1:0] above, cur, below, row0, new_row;

  logic                 in_grid;
  logic [ROW_W-1:0]     x_idx, y_idx, y_req;
  logic [GRID_SIDE-1:0] patched_row;
  logic [ROW_W:0]       row_plus1, row_plus2;
  logic                 last_row, last_col, slot_free;
  window_t              win;
  logic                 cell_next;

  assign in_grid   = (32'(cmd.cell_x) < GRID_SIDE) && (32'(cmd.cell_y) < GRID_SIDE);
  assign x_idx     = ROW_W'(cmd.cell_x);
  assign y_idx     = ROW_W'(cmd.cell_y);
  assign y_req     = ROW_W'(req.cell_y);
  assign row_plus1 = {1'b0, row} + (ROW_W+1)'(1);
  assign row_plus2 = {1'b0, row} + (ROW_W+1)'(2);
  assign last_row  = (row == ROW_W'(GRID_SIDE - 1));
  assign last_col  = (col == ROW_W'(GRID_SIDE - 1));
  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  always_comb begin
    patched_row        = rd_data;
    patched_row[x_idx] = cmd.write_value;
  end

  // column under evaluation sits at bit 0 of the rotating rows
  assign win.up  = {above[1], above[0], above[GRID_SIDE-1]};
  assign win.mid = {cur[1],   cur[0],   cur[GRID_SIDE-1]};
  assign win.dn  = {below[1], below[0], below[GRID_SIDE-1]};

  tlge_cell_rule u_rule (
    .win   (win),
    .alive (cell_next)
  );

  // cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_grid[mem_waddr] <= mem_wdata;
    end
    rd_data <= cell_grid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = row;
    mem_wdata  = '0;
    rd_addr    = '0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (last_row) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          if (req.opcode == OP_STEP) begin
            rd_addr    = ROW_W'(GRID_SIDE - 1);
            state_next = ST_LOAD_UP;
          end else if (req.opcode == OP_WRITE || req.opcode == OP_READ) begin
            rd_addr    = y_req;
            state_next = ST_ACCESS;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_ACCESS: begin
        mem_we     = (cmd.opcode == OP_WRITE) && in_grid;
        mem_waddr  = y_idx;
        mem_wdata  = patched_row;
        state_next = ST_DONE;
      end
      ST_LOAD_UP: begin
        state_next = ST_LOAD_CUR;
      end
      ST_LOAD_CUR: begin
        rd_addr    = ROW_W'(1);
        state_next = ST_LOAD_DN;
      end
      ST_LOAD_DN: begin
        state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (last_col) begin
          state_next = ST_WRITEBACK;
        end
      end
      ST_WRITEBACK: begin
        mem_we    = 1'b1;
        mem_wdata = new_row;
        if (row_plus2 < (ROW_W+1)'(GRID_SIDE)) begin
          rd_addr = row_plus2[ROW_W-1:0];
        end
        state_next = last_row ? ST_DONE : ST_LOAD_DN;
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else begin
      case (state)
        ST_CLEAR:     row <= last_row ? '0 : row + ROW_W'(1);
        ST_LOAD_CUR:  row <= '0;
        ST_WRITEBACK: row <= last_row ? '0 : row + ROW_W'(1);
        default:      row <= row;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd    <= req;
          rd_bit <= 1'b0;
        end
      end
      ST_ACCESS: begin
        rd_bit <= (cmd.opcode == OP_READ) && in_grid && rd_data[x_idx];
      end
      ST_LOAD_UP: begin
        above <= rd_data;
      end
      ST_LOAD_CUR: begin
        cur  <= rd_data;
        row0 <= rd_data;
      end
      ST_LOAD_DN: begin
        // bottom neighbor of the last row is the original top row
        below <= (row_plus1 == (ROW_W+1)'(GRID_SIDE)) ? row0 : rd_data;
        col   <= '0;
      end
      ST_SWEEP: begin
        above   <= {above[0], above[GRID_SIDE-1:1]};
        cur     <= {cur[0],   cur[GRID_SIDE-1:1]};
        below   <= {below[0], below[GRID_SIDE-1:1]};
        new_row <= {cell_next, new_row[GRID_SIDE-1:1]};
        col     <= col + ROW_W'(1);
      end
      ST_WRITEBACK: begin
        above <= cur;
        cur   <= below;
      end
      default: begin
        col <= col;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && slot_free) begin
      rsp.read_value  <= rd_bit;
      rsp.finished_op <= cmd.opcode;
    end
  end

endmodule

/* design/tlge_cell_rule.sv */
// ----------------------------------------------------------------------------
// tlge_cell_rule: B3/S23 next-state unit
// Counts the eight neighbors of one cell and applies the birth/survive rule.
// ----------------------------------------------------------------------------
module tlge_cell_rule (
  input  tlge_pkg::window_t win,
  output logic              alive
);
  import tlge_pkg::*;

  logic [3:0] live;

  assign live = 4'(win.up[0]) + 4'(win.up[1]) + 4'(win.up[2]) +
                4'(win.mid[0]) + 4'(win.mid[2]) +
                4'(win.dn[0]) + 4'(win.dn[1]) + 4'(win.dn[2]);

  assign alive = win.mid[1] ? ((live == KEEP_LOW) || (live == KEEP_HIGH))
                            : (live == BIRTH_COUNT);

endmodule

/* design/tlge_checker.sv */
// ----------------------------------------------------------------------------
// tlge_checker: port-level checks for the toroidal life engine
// Watches both channels over time; bound to the top level below.
// ----------------------------------------------------------------------------
module tlge_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input tlge_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input tlge_pkg::rsp_t rsp
);
  import tlge_pkg::*;

  // hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // clearing pass keeps requests out right after reset
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> req_stall)
    else $error("request taken during clearing pass");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous one in flight");

  // only reads return a live cell
  a_read_value_only_read: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.finished_op == OP_READ) || !rsp.read_value)
    else $error("read_value set for non-read request");

  // a new response appears only while the block is busy
  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response without request in flight");

endmodule

bind toroidal_life_generation_engine tlge_checker u_tlge_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
